>>> rtl/sga_pkg.sv
// Shared types and codes for the sorted group aggregate block.
// Used by every module of the block; depends on nothing.
package sga_pkg;

   // Aggregate function codes held in the function select register.
   localparam logic [2:0] FN_AVG      = 3'd0;
   localparam logic [2:0] FN_MAX      = 3'd1;
   localparam logic [2:0] FN_MIN      = 3'd2;
   localparam logic [2:0] FN_SUM      = 3'd3;
   localparam logic [2:0] FN_NN_COUNT = 3'd4;
   localparam logic [2:0] FN_ROW_COUNT = 3'd5;

   // Register index, taken from address bit 2.
   localparam logic REG_FUNCTION_SELECT = 1'b0;
   localparam logic REG_GROUPED_MODE    = 1'b1;

   localparam logic [2:0] FUNCTION_SELECT_RESET = FN_SUM;
   localparam logic       GROUPED_MODE_RESET    = 1'b1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic               end_of_stream;
      logic [31:0]        group_key;
      logic signed [31:0] col_value;
      logic               value_is_null;
   } req_type;

   typedef struct packed {
      logic [31:0]        out_key;
      logic signed [63:0] aggregate_result;
      logic               result_is_null;
      logic [31:0]        group_row_count;
   } rsp_type;

   // Commands from the sequencer to the accumulator bank.
   typedef struct packed {
      logic update;
      logic clear_acc;
      logic load_key;
      logic drop_key;
      logic feed;
   } acc_ctrl_type;

   typedef struct packed {
      logic [31:0] current_key;
      logic        key_valid;
      logic [31:0] running_min;
      logic [31:0] running_max;
      logic [63:0] running_sum;
      logic [31:0] nonnull_count;
      logic [31:0] row_count;
   } acc_state_type;

endpackage

>>> rtl/sga_div.sv
// Iterative unsigned divider, one quotient bit per cycle (64 by 32 bits).
// Depends on sga_pkg.
module sga_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   import sga_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  count_ff, count_in;
   logic [63:0] quot_ff, quot_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] divisor_ff, divisor_in;
   logic [32:0] trial;
   logic [32:0] diff;
   logic        fits;

   // Restoring step: the partial remainder always stays below the divisor.
   assign trial = {rem_ff, quot_ff[63]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         quot_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[31:0] : trial[31:0];
         quot_in  = {quot_ff[62:0], fits};
         count_in = count_ff + 6'd1;
         if (count_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

>>> rtl/sga_acc.sv
// Accumulator bank: open group key, min, max, wrapping sum and counts.
// Depends on sga_pkg.
module sga_acc (
   input  logic                  clock,
   input  logic                  reset,
   input  sga_pkg::acc_ctrl_type ctrl,
   input  logic [31:0]           row_key,
   input  logic [31:0]           row_value,
   input  logic                  row_is_null,
   output sga_pkg::acc_state_type acc
);
   import sga_pkg::*;

   acc_state_type acc_ff, acc_in;
   acc_state_type base;
   logic [63:0]   value_ext;

   assign value_ext = {{32{row_value[31]}}, row_value};

   always_comb begin
      base = acc_ff;
      if (ctrl.clear_acc) begin
         base.running_min   = '0;
         base.running_max   = '0;
         base.running_sum   = '0;
         base.nonnull_count = '0;
         base.row_count     = '0;
      end
      if (ctrl.load_key) begin
         base.current_key = row_key;
         base.key_valid   = 1'b1;
      end
      if (ctrl.drop_key) begin
         base.current_key = '0;
         base.key_valid   = 1'b0;
      end
      acc_in = base;
      if (ctrl.feed) begin
         if (!row_is_null) begin
            if (base.nonnull_count == '0) begin
               acc_in.running_min = row_value;
               acc_in.running_max = row_value;
               acc_in.running_sum = value_ext;
            end else begin
               if ($signed(row_value) < $signed(base.running_min)) begin
                  acc_in.running_min = row_value;
               end
               if ($signed(row_value) > $signed(base.running_max)) begin
                  acc_in.running_max = row_value;
               end
               acc_in.running_sum = base.running_sum + value_ext;
            end
            if (base.nonnull_count != COUNT_MAX) begin
               acc_in.nonnull_count = base.nonnull_count + 32'd1;
            end
         end
         if (base.row_count != COUNT_MAX) begin
            acc_in.row_count = base.row_count + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (ctrl.update) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

>>> rtl/sorted_group_aggregate_top.sv
// Top level of the sorted group aggregate block: sequencer, registers,
// result register. Depends on sga_pkg, sga_acc and sga_div.

// Group-by aggregation over rows that arrive sorted by key. Each input
// transfer carries one row (key, signed 32-bit value, null flag) or an end
// marker. A row with no result passes through the cycle of the transfer
// and an update cycle. A row or end marker that closes a group also passes
// through an output state that loads the result once the result register
// is free. When the average is selected and the group saw a non-null value,
// the quotient comes from a one-bit-per-cycle divider and the sequencer
// waits in a divide state until it is done. req_stall is high from the
// cycle after a transfer until the item is finished, and a finished result
// waits in the output register while the next row is taken, so a result that
// is not collected only holds the block up when the next group closes. Both
// counts saturate at all ones, the sum wraps at 64 bits, and min, max, sum and
// average report null for a group without a non-null value. Registers:
// function_select at byte address 0 (0 avg, 1 max, 2 min, 3 sum, 4 non-null
// count, 5 row count), grouped_mode at byte address 4; write them only while
// the block is idle.
module sorted_group_aggregate_top (
   input  logic                          clock,
   input  logic                          reset,
   // Row input
   input  logic                          req_valid,
   output logic                          req_stall,
   input  sga_pkg::req_type              req_data,
   // Result output
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output sga_pkg::rsp_type              rsp_data,
   // Register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [sga_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [sga_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [sga_pkg::CSR_DATA_W-1:0] prdata,
   output logic                          pready
);
   import sga_pkg::*;

   // Sequencer states.
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_OUT  = 2'd2;
   localparam logic [1:0] S_UPD  = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [2:0]    fsel_ff, fsel_in;
   logic          grouped_ff, grouped_in;
   req_type       item_ff, item_in;
   logic [31:0]   emit_key_ff, emit_key_in;
   logic          neg_ff, neg_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   acc_ctrl_type  acc_ctrl;
   acc_state_type acc;

   logic          accept;
   logic          csr_write;
   logic          emit_now;
   logic          none_seen;
   logic          div_start;
   logic          div_done;
   logic [63:0]   div_quot;
   logic [63:0]   sum_mag;
   logic          out_free;
   logic          new_group;
   logic [63:0]   result_val;
   logic          result_null;

   // ---------------------------------------------------------------------
   // Register port: no wait states, registers decoded by address bit 2.
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      fsel_in    = fsel_ff;
      grouped_in = grouped_ff;
      if (csr_write) begin
         unique case (paddr[2])
            REG_FUNCTION_SELECT: fsel_in    = pwdata[2:0];
            REG_GROUPED_MODE:    grouped_in = pwdata[0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_FUNCTION_SELECT: prdata = {{(CSR_DATA_W-3){1'b0}}, fsel_ff};
         REG_GROUPED_MODE:    prdata = {{(CSR_DATA_W-1){1'b0}}, grouped_ff};
      endcase
   end

   // ---------------------------------------------------------------------
   // Decisions taken in the cycle of the input transfer, while the
   // accumulators still describe the group that may be closing.
   // ---------------------------------------------------------------------
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign none_seen = (acc.nonnull_count == '0);

   always_comb begin
      if (grouped_ff) begin
         if (req_data.end_of_stream) begin
            emit_now = acc.key_valid;
         end else begin
            emit_now = acc.key_valid && (req_data.group_key != acc.current_key);
         end
      end else begin
         emit_now = req_data.end_of_stream;
      end
   end

   // Average works on the magnitude of the sum and restores the sign after.
   assign sum_mag   = acc.running_sum[63] ? (64'd0 - acc.running_sum) : acc.running_sum;
   assign div_start = accept && emit_now && (fsel_ff == FN_AVG) && !none_seen;

   sga_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_mag),
      .divisor  (acc.nonnull_count),
      .done     (div_done),
      .quotient (div_quot)
   );

   // ---------------------------------------------------------------------
   // Result selection, loaded into the output register in the output state.
   // ---------------------------------------------------------------------
   always_comb begin
      result_val  = '0;
      result_null = 1'b0;
      unique case (fsel_ff)
         FN_AVG: begin
            if (none_seen) begin
               result_null = 1'b1;
            end else begin
               result_val = neg_ff ? (64'd0 - div_quot) : div_quot;
            end
         end
         FN_MAX: begin
            if (none_seen) begin
               result_null = 1'b1;
            end else begin
               result_val = {{32{acc.running_max[31]}}, acc.running_max};
            end
         end
         FN_MIN: begin
            if (none_seen) begin
               result_null = 1'b1;
            end else begin
               result_val = {{32{acc.running_min[31]}}, acc.running_min};
            end
         end
         FN_SUM: begin
            if (none_seen) begin
               result_null = 1'b1;
            end else begin
               result_val = acc.running_sum;
            end
         end
         FN_NN_COUNT:  result_val = {32'd0, acc.nonnull_count};
         FN_ROW_COUNT: result_val = {32'd0, acc.row_count};
         default:      result_null = 1'b1;
      endcase
   end

   // The output register is free when empty or being drained this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------------
   // Sequencer.
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      emit_key_in  = emit_key_ff;
      neg_in       = neg_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               item_in     = req_data;
               emit_key_in = grouped_ff ? acc.current_key : 32'd0;
               neg_in      = acc.running_sum[63];
               if (!emit_now) begin
                  state_in = S_UPD;
               end else if (div_start) begin
                  state_in = S_DIV;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_in.out_key          = emit_key_ff;
               rsp_in.aggregate_result = result_val;
               rsp_in.result_is_null   = result_null;
               rsp_in.group_row_count  = acc.row_count;
               rsp_valid_in            = 1'b1;
               state_in                = S_UPD;
            end
         end
         S_UPD: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Accumulator commands for the update cycle.
   assign new_group = !acc.key_valid || (item_ff.group_key != acc.current_key);

   always_comb begin
      acc_ctrl = '0;
      if (state_ff == S_UPD) begin
         acc_ctrl.update = 1'b1;
         if (item_ff.end_of_stream) begin
            // Any end marker closes the stream and clears everything.
            acc_ctrl.clear_acc = 1'b1;
            acc_ctrl.drop_key  = 1'b1;
         end else if (grouped_ff) begin
            acc_ctrl.clear_acc = new_group;
            acc_ctrl.load_key  = new_group;
            acc_ctrl.feed      = 1'b1;
         end else begin
            acc_ctrl.feed = 1'b1;
         end
      end
   end

   sga_acc u_acc (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (acc_ctrl),
      .row_key     (item_ff.group_key),
      .row_value   (item_ff.col_value),
      .row_is_null (item_ff.value_is_null),
      .acc         (acc)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fsel_ff      <= FUNCTION_SELECT_RESET;
         grouped_ff   <= GROUPED_MODE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fsel_ff      <= fsel_in;
         grouped_ff   <= grouped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      emit_key_ff <= emit_key_in;
      neg_ff      <= neg_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/sga_checker.sv
// Port-level checks for the sorted group aggregate block, with its bind.
// Depends on sga_pkg and sorted_group_aggregate_top.
module sga_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input sga_pkg::rsp_type rsp_data
);
   import sga_pkg::*;

   // A stalled result stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or was withdrawn");

   // The block always stalls its input in the cycle after an input transfer.
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again directly after a transfer");

   // A new result only appears while an item is being worked on.
   a_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_stall)
      else $error("result appeared with no item in progress");

   // A null aggregate carries a zero value.
   a_null_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_is_null |-> rsp_data.aggregate_result == 64'sd0)
      else $error("null result with non-zero value");

endmodule

bind sorted_group_aggregate_top sga_checker u_sga_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> tb/sv/sga_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the sorted group aggregate block: watches the row, result and
// register channels, predicts every result row and compares it field by field.
// Depends on sga_pkg for the payload types, function codes and reset values.
module sga_result_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  sga_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  sga_pkg::rsp_type               rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic                           pready,
   input  logic [sga_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [sga_pkg::CSR_DATA_W-1:0] pwdata,
   output int                             mismatches,
   output int                             groups_owed
);
   import sga_pkg::*;

   localparam int PRINT_LIMIT = 200;

   // Shadow copy of the registers and of the group being folded.
   logic [2:0]         fn_sel;
   logic               grp_mode;
   logic [31:0]        cur_key;
   logic               key_open;
   logic signed [31:0] low_val;
   logic signed [31:0] high_val;
   logic [63:0]        total;
   logic [31:0]        nonnull_rows;
   logic [31:0]        all_rows;

   rsp_type pending_groups[$];

   task automatic report_mismatch(input string what);
      if (mismatches < PRINT_LIMIT) $display("[%0t] result mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   task automatic clear_totals();
      low_val      = '0;
      high_val     = '0;
      total        = '0;
      nonnull_rows = '0;
      all_rows     = '0;
   endtask

   task automatic fold_row(input logic signed [31:0] value, input logic is_null);
      if (!is_null) begin
         if (nonnull_rows == 0) begin
            low_val  = value;
            high_val = value;
            total    = {{32{value[31]}}, value};
         end else begin
            if (value < low_val) low_val = value;
            if (value > high_val) high_val = value;
            total = total + {{32{value[31]}}, value};
         end
         if (nonnull_rows != COUNT_MAX) nonnull_rows++;
      end
      if (all_rows != COUNT_MAX) all_rows++;
   endtask

   // Works out the result row of the group now closing and queues it.
   task automatic close_group(input logic [31:0] key);
      rsp_type    row;
      logic       none;
      logic [63:0] mag;
      logic [63:0] quo;
      row.out_key          = key;
      row.aggregate_result = '0;
      row.result_is_null   = 1'b0;
      row.group_row_count  = all_rows;
      none = (nonnull_rows == 0);
      case (fn_sel)
         FN_AVG: begin
            if (none) row.result_is_null = 1'b1;
            else begin
               // Divide magnitudes so that the quotient truncates toward zero.
               mag = total[63] ? -total : total;
               quo = mag / {32'd0, nonnull_rows};
               row.aggregate_result = total[63] ? -quo : quo;
            end
         end
         FN_MAX: begin
            if (none) row.result_is_null = 1'b1;
            else row.aggregate_result = {{32{high_val[31]}}, high_val};
         end
         FN_MIN: begin
            if (none) row.result_is_null = 1'b1;
            else row.aggregate_result = {{32{low_val[31]}}, low_val};
         end
         FN_SUM: begin
            if (none) row.result_is_null = 1'b1;
            else row.aggregate_result = total;
         end
         FN_NN_COUNT:  row.aggregate_result = {32'd0, nonnull_rows};
         FN_ROW_COUNT: row.aggregate_result = {32'd0, all_rows};
         default:      row.result_is_null = 1'b1;
      endcase
      pending_groups.insert(pending_groups.size(), row);
   endtask

   task automatic predict_item(input req_type item);
      if (grp_mode) begin
         if (item.end_of_stream) begin
            if (key_open) close_group(cur_key);
            key_open = 1'b0;
            cur_key  = '0;
            clear_totals();
         end else begin
            if (!key_open) begin
               // A fresh group drops anything gathered while ungrouped.
               clear_totals();
               cur_key  = item.group_key;
               key_open = 1'b1;
            end else if (item.group_key != cur_key) begin
               close_group(cur_key);
               clear_totals();
               cur_key = item.group_key;
            end
            fold_row(item.col_value, item.value_is_null);
         end
      end else begin
         if (item.end_of_stream) begin
            close_group('0);
            key_open = 1'b0;
            cur_key  = '0;
            clear_totals();
         end else begin
            fold_row(item.col_value, item.value_is_null);
         end
      end
   endtask

   task automatic compare_row(input rsp_type seen);
      rsp_type want;
      if (pending_groups.size() == 0) begin
         report_mismatch($sformatf("result with none expected, key %h", seen.out_key));
      end else begin
         want = pending_groups.pop_front();
         if (seen.out_key !== want.out_key)
            report_mismatch($sformatf("out_key %h, expected %h", seen.out_key, want.out_key));
         if (seen.aggregate_result !== want.aggregate_result)
            report_mismatch($sformatf("aggregate_result %0d, expected %0d (key %h)",
                                      seen.aggregate_result, want.aggregate_result,
                                      want.out_key));
         if (seen.result_is_null !== want.result_is_null)
            report_mismatch($sformatf("result_is_null %b, expected %b (key %h)",
                                      seen.result_is_null, want.result_is_null, want.out_key));
         if (seen.group_row_count !== want.group_row_count)
            report_mismatch($sformatf("group_row_count %0d, expected %0d (key %h)",
                                      seen.group_row_count, want.group_row_count,
                                      want.out_key));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fn_sel   = FUNCTION_SELECT_RESET;
         grp_mode = GROUPED_MODE_RESET;
         cur_key  = '0;
         key_open = 1'b0;
         clear_totals();
         pending_groups.delete();
         mismatches = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[2])
               REG_FUNCTION_SELECT: fn_sel   = pwdata[2:0];
               REG_GROUPED_MODE:    grp_mode = pwdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) compare_row(rsp_data);
         if (req_valid && !req_stall) predict_item(req_data);
      end
      groups_owed = pending_groups.size();
   end

endmodule

>>> tb/sv/tb_sorted_group_aggregate_top.sv
`timescale 1ns / 1ps
// Top level of the sorted group aggregate testbench: clock, reset, row stimulus,
// register writes, result back-pressure and the verdict. Depends on sga_pkg,
// sga_result_checker and the block's top level.
module tb_sorted_group_aggregate_top;
   import sga_pkg::*;

   localparam int TOTAL_ITEMS      = 1450;
   // Phases that begin within the last stretch of rows run with no idling on either side.
   localparam int CALM_TAIL        = 150;
   // This comfortably covers any row still in flight once the last
   // expected result has arrived.
   localparam int QUIET_CYCLES     = 100;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int HOLD_PHASE       = 3;
   // Longest correct stretch without a transfer is the long hold plus one
   // average close and a stall burst; the watchdog allows ten times that.
   localparam int WATCHDOG_LIMIT   = 5000;

   // Function codes beyond the defined six; the block reports them as null.
   localparam logic [2:0] FN_SPARE_LO = 3'd6;
   localparam logic [2:0] FN_SPARE_HI = 3'd7;

   localparam logic [CSR_ADDR_W-1:0] ADDR_FUNCTION_SELECT = {REG_FUNCTION_SELECT, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_GROUPED_MODE    = {REG_GROUPED_MODE, 2'b00};

   localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic [31:0]        KEY_MAX   = 32'hFFFF_FFFF;

   // Every input is given a known value from time zero.
   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int   mismatches;
   int   groups_owed;
   int   item_count    = 0;
   int   quiet_run     = 0;
   // Shared between the row sender and the result receiver.
   logic idling_on     = 1'b0;
   logic hold_rsp_long = 1'b0;

   sorted_group_aggregate_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   sga_result_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .mismatches  (mismatches),
      .groups_owed (groups_owed)
   );

   // 8 ns clock period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The watchdog counts cycles in which no transfer of any kind takes place.
   // Reaching the limit means the block has hung, so the run ends there.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable)) begin
         quiet_run <= 0;
      end else if (quiet_run == WATCHDOG_LIMIT) begin
         $display("tb_sorted_group_aggregate_top failed");
         $finish;
      end else begin
         quiet_run <= quiet_run + 1;
      end
   end

   // Result receiver. It stalls in random bursts while idling is on, and once
   // in the run holds off for a long stretch so that the result register stays
   // full, the next group close cannot finish and the block stalls its input.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp_long) begin
            hold_rsp_long = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic req_type row_item(input logic [31:0] key, input logic signed [31:0] value,
                                        input logic is_null);
      req_type item;
      item.end_of_stream = 1'b0;
      item.group_key     = key;
      item.col_value     = value;
      item.value_is_null = is_null;
      return item;
   endfunction

   // An end marker carries random content in the fields that it ignores.
   function automatic req_type eos_item();
      req_type item;
      item.end_of_stream = 1'b1;
      item.group_key     = $urandom;
      item.col_value     = $urandom;
      item.value_is_null = 1'($urandom_range(0, 1));
      return item;
   endfunction

   // Values lean on the extremes and on small numbers, where the min, max and
   // average edge cases live, with plenty of full-range values besides.
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return VALUE_MIN;
         1:       return VALUE_MAX;
         2, 3:    return $signed(32'($urandom_range(0, 40))) - 32'sd20;
         default: return $urandom;
      endcase
   endfunction

   // One row transfer. While idling is on, the sender may first drop valid for
   // a random burst; valid then stays high, with the payload held, until the
   // block takes the row.
   task automatic send_item(input req_type item);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      item_count++;
   endtask

   // Stops offering rows, waits for every outstanding result and then lets
   // the block finish any row that closes no group.
   task automatic settle();
      req_valid <= 1'b0;
      while (groups_owed != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // A register write: setup cycle, then access cycle, completing at the edge
   // where pready is seen high.
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic configure(input logic [2:0] fn, input logic grouped);
      settle();
      csr_write(ADDR_FUNCTION_SELECT, {29'd0, fn});
      csr_write(ADDR_GROUPED_MODE, {31'd0, grouped});
   endtask

   // One stream of rows in runs of equal key: up to five groups of one to six rows, then
   // the end marker. Now and then a stray row or end marker is slipped in, or
   // the stream is left without its end marker so that the next one runs on.
   task automatic send_stream();
      logic [31:0] key;
      int          groups;
      int          rows;
      logic        broken;
      case ($urandom_range(0, 7))
         0:       key = '0;
         1:       key = KEY_MAX;
         default: key = $urandom;
      endcase
      groups = $urandom_range(0, 5);
      broken = ($urandom_range(0, 7) == 0);
      for (int g = 0; g < groups; g++) begin
         rows = $urandom_range(1, 6);
         for (int r = 0; r < rows; r++) begin
            if ($urandom_range(0, 15) == 0)
               send_item($urandom_range(0, 1) ? eos_item()
                                             : row_item($urandom, pick_value(),
                                                        1'($urandom_range(0, 1))));
            send_item(row_item(key, pick_value(), $urandom_range(0, 4) == 0));
         end
         key = key + ($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 1000));
      end
      if (!broken) send_item(eos_item());
   endtask

   initial begin
      logic [2:0] fn;
      logic       grouped;
      int         phase;
      int         phase_goal;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. First with the reset settings, sum and grouped: an end
      // marker with no open group gives nothing, then the key extremes and
      // the value extremes with a null row mixed in.
      send_item(eos_item());
      send_item(row_item('0, VALUE_MAX, 1'b0));
      send_item(row_item('0, VALUE_MAX, 1'b0));
      send_item(row_item('0, pick_value(), 1'b1));
      send_item(row_item(KEY_MAX, VALUE_MIN, 1'b0));
      send_item(row_item(KEY_MAX, -32'sd1, 1'b1));
      send_item(eos_item());

      // Average of a negative sum truncates toward zero; an all-null group
      // gives a null average.
      configure(FN_AVG, 1'b1);
      send_item(row_item(32'd5, -32'sd7, 1'b0));
      send_item(row_item(32'd5, 32'sd2, 1'b0));
      send_item(row_item(32'd6, pick_value(), 1'b1));
      send_item(eos_item());

      // Ungrouped: an empty stream still yields one null row, then a minimum.
      configure(FN_MIN, 1'b0);
      send_item(eos_item());
      send_item(row_item($urandom, VALUE_MIN, 1'b0));
      send_item(row_item($urandom, VALUE_MAX, 1'b0));
      send_item(eos_item());

      // Rows gathered ungrouped are dropped by the first grouped row with no
      // open group. A group left open across a switch to ungrouped keeps its
      // key, gathers the ungrouped rows and carries on once grouped again.
      configure(FN_MAX, 1'b0);
      send_item(row_item($urandom, 32'sd3, 1'b0));
      send_item(row_item($urandom, -32'sd9, 1'b0));
      configure(FN_MAX, 1'b1);
      send_item(row_item(32'd9, 32'sd1, 1'b0));
      configure(FN_NN_COUNT, 1'b0);
      send_item(row_item($urandom, 32'sd100, 1'b0));
      configure(FN_ROW_COUNT, 1'b1);
      send_item(row_item(32'd9, pick_value(), 1'b1));
      send_item(eos_item());

      // The two spare function codes.
      configure(FN_SPARE_LO, 1'b1);
      send_item(row_item(32'd1, pick_value(), 1'b0));
      send_item(eos_item());
      configure(FN_SPARE_HI, 1'b1);
      send_item(row_item(32'd2, pick_value(), 1'b0));
      send_item(eos_item());

      // Random part, in phases of random settings. Idling is switched on for
      // most phases, off for some, and off for phases begun in the closing stretch.
      phase = 0;
      while (item_count < TOTAL_ITEMS) begin
         fn      = 3'($urandom_range(0, 7));
         grouped = ($urandom_range(0, 3) != 0);
         if (phase == HOLD_PHASE) grouped = 1'b1;
         configure(fn, grouped);
         idling_on = (item_count < TOTAL_ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
         if (phase == HOLD_PHASE) hold_rsp_long = 1'b1;
         phase_goal = item_count + $urandom_range(40, 120);
         while (item_count < phase_goal) send_stream();
         phase++;
      end

      settle();
      if (mismatches == 0 && groups_owed == 0) begin
         $display("tb_sorted_group_aggregate_top passed");
      end else begin
         $display("tb_sorted_group_aggregate_top failed");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/sga_pkg.sv
rtl/sga_div.sv
rtl/sga_acc.sv
rtl/sorted_group_aggregate_top.sv
rtl/sga_checker.sv
tb/sv/sga_result_checker.sv
tb/sv/tb_sorted_group_aggregate_top.sv
